// ===== rtl/icrp_pkg.sv =====
// ----------------------------------------------------------------------------
// icrp_pkg: shared types and constants of the input change recorder/player
// Key layout, command and status codes, and the sequencer interface types.
// ----------------------------------------------------------------------------
`default_nettype none

package icrp_pkg;

	localparam int MAX_KEYS = 4096;
	localparam int KEY_AW   = $clog2(MAX_KEYS);
	localparam int KEY_CW   = $clog2(MAX_KEYS + 1);

	localparam int TURN_W   = 16;
	localparam int BTN_W    = 64;
	localparam int FRAME_W  = 32;
	localparam int TOTAL_W  = 13;
	localparam int KEY_W    = 2 * TURN_W + BTN_W + FRAME_W;

	localparam logic [1:0] CMD_CLEAR  = 2'd0;
	localparam logic [1:0] CMD_RECORD = 2'd1;
	localparam logic [1:0] CMD_PLAY   = 2'd2;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic signed [TURN_W-1:0] lr;
		logic signed [TURN_W-1:0] ud;
		logic [BTN_W-1:0]         btn;
		logic [FRAME_W-1:0]       time_stamp;
	} key_t;

	typedef enum logic [1:0] {
		SQ_IDLE,
		SQ_SEARCH,
		SQ_KEY,
		SQ_PREV
	} seq_state_t;

	typedef struct packed {
		logic              en;
		logic [KEY_AW-1:0] addr;
	} ram_req_t;

	typedef struct packed {
		logic busy;
		logic key_vld;
		logic exact;
		logic prev_vld;
		logic done;
	} seq_stat_t;

endpackage

`default_nettype wire

// ===== rtl/icrp_ram.sv =====
// ----------------------------------------------------------------------------
// icrp_ram: generic single-port RAM
// One read or one write per cycle, with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module icrp_ram #(
	parameter int WIDTH = 128,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     en,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem_q[addr] <= wdata;
			end else begin
				rdata_q <= mem_q[addr];
			end
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/icrp_seq.sv =====
// ----------------------------------------------------------------------------
// icrp_seq: playback sequencer with a shared time compare unit
// Binary search over the stored key times, one RAM read per step, then
// fetches of the found key and, on an exact match, of the key before it.
// ----------------------------------------------------------------------------
`default_nettype none

module icrp_seq (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	input  wire logic [icrp_pkg::KEY_CW-1:0]     key_count,
	input  wire logic [icrp_pkg::FRAME_W-1:0]    frame,
	input  wire icrp_pkg::key_t                  rkey,
	output icrp_pkg::ram_req_t                   rd_req,
	output icrp_pkg::seq_stat_t                  stat
);

	localparam int CW = icrp_pkg::KEY_CW;
	localparam int AW = icrp_pkg::KEY_AW;

	icrp_pkg::seq_state_t state_q, state_d;

	logic [CW-1:0]                 lo_q, hi_q, n_q;
	logic [AW-1:0]                 mid_q;
	logic [icrp_pkg::FRAME_W-1:0]  frame_q;

	logic          le, exact, search_end;
	logic [CW-1:0] lo_n, hi_n, mid_n;
	logic [CW:0]   sum_n;

	always_comb begin
		le         = rkey.time_stamp <= frame_q;
		exact      = rkey.time_stamp == frame_q;
		lo_n       = le ? (CW'(mid_q) + CW'(1)) : lo_q;
		hi_n       = le ? hi_q : CW'(mid_q);
		sum_n      = {1'b0, lo_n} + {1'b0, hi_n};
		mid_n      = sum_n[CW:1];
		search_end = lo_n == hi_n;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			icrp_pkg::SQ_IDLE: begin
				if (start) begin
					state_d = icrp_pkg::SQ_SEARCH;
				end
			end
			icrp_pkg::SQ_SEARCH: begin
				if (search_end) begin
					state_d = (lo_n == '0) ? icrp_pkg::SQ_IDLE : icrp_pkg::SQ_KEY;
				end
			end
			icrp_pkg::SQ_KEY: begin
				if (exact && (n_q >= CW'(2))) begin
					state_d = icrp_pkg::SQ_PREV;
				end else begin
					state_d = icrp_pkg::SQ_IDLE;
				end
			end
			icrp_pkg::SQ_PREV: begin
				state_d = icrp_pkg::SQ_IDLE;
			end
			default: begin
				state_d = icrp_pkg::SQ_IDLE;
			end
		endcase
	end

	always_comb begin
		rd_req        = '0;
		stat          = '0;
		stat.busy     = state_q != icrp_pkg::SQ_IDLE;
		unique case (state_q)
			icrp_pkg::SQ_IDLE: begin
				if (start) begin
					rd_req.en   = 1'b1;
					rd_req.addr = AW'(key_count >> 1);
				end
			end
			icrp_pkg::SQ_SEARCH: begin
				if (!search_end) begin
					rd_req.en   = 1'b1;
					rd_req.addr = AW'(mid_n);
				end else if (lo_n != '0) begin
					rd_req.en   = 1'b1;
					rd_req.addr = AW'(lo_n - CW'(1));
				end else begin
					stat.done = 1'b1;
				end
			end
			icrp_pkg::SQ_KEY: begin
				stat.key_vld = 1'b1;
				stat.exact   = exact;
				if (exact && (n_q >= CW'(2))) begin
					rd_req.en   = 1'b1;
					rd_req.addr = AW'(n_q - CW'(2));
				end else begin
					stat.done = 1'b1;
				end
			end
			icrp_pkg::SQ_PREV: begin
				stat.prev_vld = 1'b1;
				stat.done     = 1'b1;
			end
			default: begin
				stat.done = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= icrp_pkg::SQ_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == icrp_pkg::SQ_IDLE && start) begin
			lo_q    <= '0;
			hi_q    <= key_count;
			mid_q   <= AW'(key_count >> 1);
			frame_q <= frame;
		end else if (state_q == icrp_pkg::SQ_SEARCH) begin
			lo_q  <= lo_n;
			hi_q  <= hi_n;
			mid_q <= AW'(mid_n);
			n_q   <= lo_n;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/input_change_recorder_player_top.sv =====
// ----------------------------------------------------------------------------
// input_change_recorder_player_top: change-keyed input recorder and player
// Clear and record requests are answered in the cycle after they are taken.
// A play request runs a binary search, one key store read per step, then reads the
// found key and, on an exact match, the key before it.
// One request is in flight at a time; a new one is taken after the result.
// Reset empties the store and zeroes the frame length; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module input_change_recorder_player_top (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  in_valid,
	output logic                                       in_stall,
	input  wire logic [1:0]                            command,
	input  wire logic signed [icrp_pkg::TURN_W-1:0]    turn_lr,
	input  wire logic signed [icrp_pkg::TURN_W-1:0]    turn_ud,
	input  wire logic [icrp_pkg::BTN_W-1:0]            buttons,
	input  wire logic [icrp_pkg::FRAME_W-1:0]          frame,
	output logic                                       out_valid,
	input  wire logic                                  out_stall,
	output logic signed [icrp_pkg::TURN_W-1:0]         play_turn_lr,
	output logic signed [icrp_pkg::TURN_W-1:0]         play_turn_ud,
	output logic [icrp_pkg::BTN_W-1:0]                 buttons_down,
	output logic [icrp_pkg::BTN_W-1:0]                 buttons_up,
	output logic [icrp_pkg::BTN_W-1:0]                 went_down,
	output logic [icrp_pkg::BTN_W-1:0]                 went_up,
	output logic [1:0]                                 status,
	output logic [icrp_pkg::TOTAL_W-1:0]               key_total,
	output logic [icrp_pkg::FRAME_W-1:0]               frame_total
);

	localparam int CW = icrp_pkg::KEY_CW;
	localparam int AW = icrp_pkg::KEY_AW;

	logic [CW-1:0]                 key_count_q;
	logic [icrp_pkg::FRAME_W-1:0]  film_q;
	logic                          out_vld_q;

	logic signed [icrp_pkg::TURN_W-1:0] lr_q, ud_q;
	logic [icrp_pkg::BTN_W-1:0]         down_q, wd_q, wu_q, last_btn_q;
	logic                               play_q;
	logic [1:0]                         status_q;

	logic                  accept, add_key, is_full, wr_en, start, empty;
	icrp_pkg::ram_req_t    rd_req;
	icrp_pkg::seq_stat_t   stat;
	icrp_pkg::key_t        wkey, rkey;
	logic [icrp_pkg::KEY_W-1:0] ram_rdata;
	logic                  ram_en;
	logic [AW-1:0]         ram_addr;

	always_comb begin
		in_stall = stat.busy || out_vld_q;
		accept   = in_valid && !in_stall;
		empty    = key_count_q == '0;
		is_full  = key_count_q == CW'(icrp_pkg::MAX_KEYS);
		add_key  = empty || (turn_lr != '0) || (turn_ud != '0) || (last_btn_q != buttons);
		wr_en    = accept && (command == icrp_pkg::CMD_RECORD) && add_key && !is_full;
		start    = accept && (command == icrp_pkg::CMD_PLAY) && !empty;
		wkey.lr         = turn_lr;
		wkey.ud         = turn_ud;
		wkey.btn        = buttons;
		wkey.time_stamp = film_q;
		ram_en   = wr_en || rd_req.en;
		ram_addr = wr_en ? AW'(key_count_q) : rd_req.addr;
		rkey     = icrp_pkg::key_t'(ram_rdata);
	end

	icrp_ram #(
		.WIDTH(icrp_pkg::KEY_W),
		.DEPTH(icrp_pkg::MAX_KEYS)
	) u_key_store (
		.clk   (clk),
		.en    (ram_en),
		.we    (wr_en),
		.addr  (ram_addr),
		.wdata (wkey),
		.rdata (ram_rdata)
	);

	icrp_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.key_count (key_count_q),
		.frame     (frame),
		.rkey      (rkey),
		.rd_req    (rd_req),
		.stat      (stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_count_q <= '0;
			film_q      <= '0;
			out_vld_q   <= 1'b0;
		end else begin
			if (accept && command == icrp_pkg::CMD_CLEAR) begin
				key_count_q <= '0;
				film_q      <= '0;
			end else if (accept && command == icrp_pkg::CMD_RECORD) begin
				if (wr_en) begin
					key_count_q <= key_count_q + CW'(1);
				end
				if (film_q != '1) begin
					film_q <= film_q + icrp_pkg::FRAME_W'(1);
				end
			end
			if (accept && !start) begin
				out_vld_q <= 1'b1;
			end else if (stat.done) begin
				out_vld_q <= 1'b1;
			end else if (out_vld_q && !out_stall) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			last_btn_q <= buttons;
		end
		if (accept) begin
			lr_q   <= '0;
			ud_q   <= '0;
			down_q <= '0;
			wd_q   <= '0;
			wu_q   <= '0;
			play_q <= command == icrp_pkg::CMD_PLAY;
			unique case (command)
				icrp_pkg::CMD_RECORD: status_q <= (add_key && is_full) ? icrp_pkg::ST_FULL
				                                                       : icrp_pkg::ST_OK;
				icrp_pkg::CMD_PLAY:   status_q <= empty ? icrp_pkg::ST_EMPTY : icrp_pkg::ST_OK;
				default:              status_q <= icrp_pkg::ST_OK;
			endcase
		end else if (stat.key_vld) begin
			down_q <= rkey.btn;
			if (stat.exact) begin
				lr_q <= rkey.lr;
				ud_q <= rkey.ud;
				wd_q <= rkey.btn;
			end
		end else if (stat.prev_vld) begin
			wd_q <= down_q & ~rkey.btn;
			wu_q <= ~down_q & rkey.btn;
		end
	end

	always_comb begin
		out_valid    = out_vld_q;
		play_turn_lr = lr_q;
		play_turn_ud = ud_q;
		buttons_down = down_q;
		buttons_up   = play_q ? ~down_q : '0;
		went_down    = wd_q;
		went_up      = wu_q;
		status       = status_q;
		key_total    = icrp_pkg::TOTAL_W'(key_count_q);
		frame_total  = film_q;
	end

endmodule

`default_nettype wire

// ===== rtl/icrp_chk.sv =====
// ----------------------------------------------------------------------------
// icrp_chk: port-level checker for the input change recorder/player
// Watches the top level's ports and is bound to every instance of it.
// ----------------------------------------------------------------------------
`default_nettype none

module icrp_chk (
	input wire logic                                clk,
	input wire logic                                arst_n,
	input wire logic                                in_valid,
	input wire logic                                in_stall,
	input wire logic                                out_valid,
	input wire logic                                out_stall,
	input wire logic [icrp_pkg::BTN_W-1:0]          buttons_down,
	input wire logic [icrp_pkg::BTN_W-1:0]          buttons_up,
	input wire logic [icrp_pkg::BTN_W-1:0]          went_down,
	input wire logic [icrp_pkg::BTN_W-1:0]          went_up,
	input wire logic [1:0]                          status,
	input wire logic [icrp_pkg::TOTAL_W-1:0]        key_total
);

	// A request that was just taken keeps the input side closed.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("request taken while another was in flight");

	a_key_total_bound: assert property (@(posedge clk) disable iff (!arst_n)
		{19'd0, key_total} <= 32'(icrp_pkg::MAX_KEYS))
		else $error("key count beyond store depth");

	a_empty_play: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == icrp_pkg::ST_EMPTY |->
		key_total == '0 && buttons_down == '0 && buttons_up == '1)
		else $error("empty-store play result is inconsistent");

	a_masks: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((buttons_up == ~buttons_down) ||
		               (buttons_up == '0 && buttons_down == '0)) &&
		              (went_down & ~buttons_down) == '0 &&
		              (went_up & buttons_down) == '0)
		else $error("button masks disagree");

endmodule

bind input_change_recorder_player_top icrp_chk u_icrp_chk (.*);

`default_nettype wire

// ===== test/input_change_recorder_player_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// input_change_recorder_player_checker: result checker for the recorder/player
// Watches both channels, keeps its own copy of the key store, the key count
// and the frame length, works out the result of every accepted request and
// compares each accepted result with the oldest one still waiting.
// ----------------------------------------------------------------------------

module input_change_recorder_player_checker
	import icrp_pkg::*;
(
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	input  wire logic                       in_stall,
	input  wire logic [1:0]                 command,
	input  wire logic signed [TURN_W-1:0]   turn_lr,
	input  wire logic signed [TURN_W-1:0]   turn_ud,
	input  wire logic [BTN_W-1:0]           buttons,
	input  wire logic [FRAME_W-1:0]         frame,
	input  wire logic                       out_valid,
	input  wire logic                       out_stall,
	input  wire logic signed [TURN_W-1:0]   play_turn_lr,
	input  wire logic signed [TURN_W-1:0]   play_turn_ud,
	input  wire logic [BTN_W-1:0]           buttons_down,
	input  wire logic [BTN_W-1:0]           buttons_up,
	input  wire logic [BTN_W-1:0]           went_down,
	input  wire logic [BTN_W-1:0]           went_up,
	input  wire logic [1:0]                 status,
	input  wire logic [TOTAL_W-1:0]         key_total,
	input  wire logic [FRAME_W-1:0]         frame_total,
	output int                              mismatches,
	output int                              outstanding
);

	localparam int REPORT_LIMIT = 200;

	typedef struct packed {
		logic [TURN_W-1:0]  lr;
		logic [TURN_W-1:0]  ud;
		logic [BTN_W-1:0]   down;
		logic [BTN_W-1:0]   up;
		logic [BTN_W-1:0]   wdown;
		logic [BTN_W-1:0]   wup;
		logic [1:0]         status;
		logic [TOTAL_W-1:0] key_total;
		logic [FRAME_W-1:0] frame_total;
	} play_result_t;

	key_t               key_mem [MAX_KEYS];
	int unsigned        key_cnt;
	logic [FRAME_W-1:0] film_len;
	play_result_t       pending_results [$];
	int unsigned        result_idx;

	function automatic int unsigned keys_up_to(input logic [FRAME_W-1:0] f);
		int unsigned lo;
		int unsigned hi;
		int unsigned mid;
		lo = 0;
		hi = key_cnt;
		while (lo < hi) begin
			mid = lo + ((hi - lo) >> 1);
			if (key_mem[mid].time_stamp <= f) begin
				lo = mid + 1;
			end else begin
				hi = mid;
			end
		end
		return lo;
	endfunction

	task automatic apply_request(input logic [1:0] cmd, input logic [TURN_W-1:0] lr,
			input logic [TURN_W-1:0] ud, input logic [BTN_W-1:0] btn,
			input logic [FRAME_W-1:0] f, output play_result_t r);
		int unsigned     n;
		logic            add;
		logic [BTN_W-1:0] prev;
		r = '0;
		r.status = ST_OK;
		case (cmd)
			CMD_CLEAR: begin
				key_cnt = 0;
				film_len = '0;
			end
			CMD_RECORD: begin
				if (key_cnt == 0) begin
					add = 1'b1;
				end else begin
					add = (lr != '0) || (ud != '0) || (key_mem[key_cnt - 1].btn != btn);
				end
				if (add) begin
					if (key_cnt >= MAX_KEYS) begin
						r.status = ST_FULL;
					end else begin
						key_mem[key_cnt] = '{lr, ud, btn, film_len};
						key_cnt++;
					end
				end
				if (film_len != '1) begin
					film_len = film_len + 1'b1;
				end
			end
			CMD_PLAY: begin
				if (key_cnt == 0) begin
					r.status = ST_EMPTY;
					n = 0;
				end else begin
					n = keys_up_to(f);
				end
				if (n == 0) begin
					r.up = '1;
				end else begin
					r.down = key_mem[n - 1].btn;
					r.up = ~key_mem[n - 1].btn;
					if (key_mem[n - 1].time_stamp == f) begin
						prev = (n >= 2) ? key_mem[n - 2].btn : '0;
						r.lr = key_mem[n - 1].lr;
						r.ud = key_mem[n - 1].ud;
						r.wdown = key_mem[n - 1].btn & ~prev;
						r.wup = ~key_mem[n - 1].btn & prev;
					end
				end
			end
			default: begin
			end
		endcase
		r.key_total = key_cnt[TOTAL_W-1:0];
		r.frame_total = film_len;
	endtask

	task automatic report_mismatch(input string msg);
		if (mismatches < REPORT_LIMIT) begin
			$display("%0t ns: %s", $realtime, msg);
		end
		mismatches++;
	endtask

	task automatic check_field(input string name, input logic [BTN_W-1:0] got,
			input logic [BTN_W-1:0] want);
		if (got !== want) begin
			report_mismatch($sformatf("result %0d %s: got %h, expected %h",
				result_idx, name, got, want));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		play_result_t want;
		play_result_t fresh;
		if (!arst_n) begin
			key_cnt = 0;
			film_len = '0;
			pending_results.delete();
			result_idx = 0;
			mismatches = 0;
			outstanding <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (pending_results.size() == 0) begin
					report_mismatch($sformatf("result %0d arrived with no request waiting",
						result_idx));
				end else begin
					want = pending_results.pop_front();
					check_field("play_turn_lr", BTN_W'(play_turn_lr[TURN_W-1:0]),
						BTN_W'(want.lr));
					check_field("play_turn_ud", BTN_W'(play_turn_ud[TURN_W-1:0]),
						BTN_W'(want.ud));
					check_field("buttons_down", buttons_down, want.down);
					check_field("buttons_up", buttons_up, want.up);
					check_field("went_down", went_down, want.wdown);
					check_field("went_up", went_up, want.wup);
					check_field("status", BTN_W'(status), BTN_W'(want.status));
					check_field("key_total", BTN_W'(key_total), BTN_W'(want.key_total));
					check_field("frame_total", BTN_W'(frame_total),
						BTN_W'(want.frame_total));
				end
				result_idx++;
			end
			if (in_valid && !in_stall) begin
				apply_request(command, turn_lr, turn_ud, buttons, frame, fresh);
				pending_results.push_back(fresh);
			end
			outstanding <= pending_results.size();
		end
	end

endmodule

// ===== test/input_change_recorder_player_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// input_change_recorder_player_top_tb: testbench of the recorder/player
// Drives directed requests, a pass that fills the key store past its limit
// and a long random run of all four commands, with random gaps on
// both channels and one long hold of the result side at the start.
// ----------------------------------------------------------------------------

module input_change_recorder_player_top_tb;
	import icrp_pkg::*;

	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int RANDOM_ITEMS = 2000;
	localparam int IDLE_LIMIT   = 4000;
	localparam int DRAIN_CYCLES = 40;

	typedef enum {
		REC_SAME,
		REC_FLIP,
		REC_MIX
	} rec_kind_t;

	logic                     clk = 1'b0;
	logic                     arst_n;
	logic                     in_valid;
	logic                     in_stall;
	logic [1:0]               command;
	logic signed [TURN_W-1:0] turn_lr;
	logic signed [TURN_W-1:0] turn_ud;
	logic [BTN_W-1:0]         buttons;
	logic [FRAME_W-1:0]       frame;
	logic                     out_valid;
	logic                     out_stall;
	logic signed [TURN_W-1:0] play_turn_lr;
	logic signed [TURN_W-1:0] play_turn_ud;
	logic [BTN_W-1:0]         buttons_down;
	logic [BTN_W-1:0]         buttons_up;
	logic [BTN_W-1:0]         went_down;
	logic [BTN_W-1:0]         went_up;
	logic [1:0]               status;
	logic [TOTAL_W-1:0]       key_total;
	logic [FRAME_W-1:0]       frame_total;

	int                       mismatches;
	int                       outstanding;
	int                       idle_cycles = 0;
	int unsigned              film_seen = 0;
	logic [BTN_W-1:0]         last_btn = '0;
	bit                       no_gaps = 1'b0;

	always #5 clk = ~clk;

	input_change_recorder_player_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.command      (command),
		.turn_lr      (turn_lr),
		.turn_ud      (turn_ud),
		.buttons      (buttons),
		.frame        (frame),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.play_turn_lr (play_turn_lr),
		.play_turn_ud (play_turn_ud),
		.buttons_down (buttons_down),
		.buttons_up   (buttons_up),
		.went_down    (went_down),
		.went_up      (went_up),
		.status       (status),
		.key_total    (key_total),
		.frame_total  (frame_total)
	);

	input_change_recorder_player_checker result_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.command      (command),
		.turn_lr      (turn_lr),
		.turn_ud      (turn_ud),
		.buttons      (buttons),
		.frame        (frame),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.play_turn_lr (play_turn_lr),
		.play_turn_ud (play_turn_ud),
		.buttons_down (buttons_down),
		.buttons_up   (buttons_up),
		.went_down    (went_down),
		.went_up      (went_up),
		.status       (status),
		.key_total    (key_total),
		.frame_total  (frame_total),
		.mismatches   (mismatches),
		.outstanding  (outstanding)
	);

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) begin
			return 0;
		end else if (r < 90) begin
			return $urandom_range(1, 3);
		end else if (r < 98) begin
			return $urandom_range(4, 10);
		end
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [BTN_W-1:0] random_mask();
		return {$urandom, $urandom};
	endfunction

	task automatic send_request(input logic [1:0] cmd, input logic [TURN_W-1:0] lr,
			input logic [TURN_W-1:0] ud, input logic [BTN_W-1:0] btn,
			input logic [FRAME_W-1:0] f);
		int gap;
		gap = no_gaps ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		turn_lr <= lr;
		turn_ud <= ud;
		buttons <= btn;
		frame <= f;
		do @(posedge clk); while (in_stall);
		if (cmd == CMD_CLEAR) begin
			film_seen = 0;
		end else if (cmd == CMD_RECORD) begin
			film_seen++;
		end
	endtask

	task automatic record_frame(input rec_kind_t kind);
		logic [TURN_W-1:0] lr;
		logic [TURN_W-1:0] ud;
		logic [BTN_W-1:0]  btn;
		int                r;
		lr = '0;
		ud = '0;
		btn = last_btn;
		case (kind)
			REC_FLIP: begin
				btn = last_btn ^ (64'd1 << $urandom_range(0, BTN_W - 1));
			end
			REC_MIX: begin
				r = $urandom_range(0, 9);
				if (r >= 9) begin
					btn = random_mask();
				end else if (r >= 8) begin
					btn = last_btn ^ random_mask();
				end else if (r >= 5) begin
					btn = last_btn ^ (64'd1 << $urandom_range(0, BTN_W - 1));
				end
				r = $urandom_range(0, 9);
				if (r >= 7) begin
					lr = TURN_W'($urandom);
				end
				if (r >= 8) begin
					ud = TURN_W'($urandom);
				end
			end
			default: begin
			end
		endcase
		last_btn = btn;
		send_request(CMD_RECORD, lr, ud, btn, $urandom);
	endtask

	task automatic play_frame();
		logic [FRAME_W-1:0] f;
		int                 r;
		r = $urandom_range(0, 9);
		if (r == 0) begin
			f = $urandom;
		end else begin
			f = $urandom_range(0, film_seen + 2);
		end
		send_request(CMD_PLAY, TURN_W'($urandom), TURN_W'($urandom), random_mask(), f);
	endtask

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		wait (idle_cycles >= IDLE_LIMIT);
		$display("input_change_recorder_player_top_tb: FAIL");
		$finish;
	end

	// The first hold keeps the result side busy while the directed requests
	// are offered, so the block has to stall its input.
	initial begin
		int span;
		int pct;
		int len;
		out_stall <= 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		out_stall <= 1'b1;
		repeat (300) @(posedge clk);
		forever begin
			if ($urandom_range(0, 19) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(150, 400)) @(posedge clk);
			end
			case ($urandom_range(0, 3))
				0: pct = 0;
				1: pct = 10;
				2: pct = 40;
				default: pct = 80;
			endcase
			span = $urandom_range(50, 200);
			while (span > 0) begin
				if ($urandom_range(0, 99) < pct) begin
					len = ($urandom_range(0, 19) == 0) ? $urandom_range(8, 30) :
						$urandom_range(1, 3);
					out_stall <= 1'b1;
					repeat (len) @(posedge clk);
					span -= len;
				end
				out_stall <= 1'b0;
				@(posedge clk);
				span--;
			end
		end
	end

	initial begin
		int keys_added;
		int r;
		in_valid <= 1'b0;
		command <= CMD_CLEAR;
		turn_lr <= '0;
		turn_ud <= '0;
		buttons <= '0;
		frame <= '0;
		arst_n <= 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_request(CMD_PLAY, '0, '0, '0, 32'd0);
		send_request(CMD_PLAY, '1, '1, '1, 32'hFFFF_FFFF);
		send_request(CMD_RECORD, '0, '0, '0, '0);
		send_request(CMD_RECORD, '0, '0, '0, '0);
		send_request(CMD_RECORD, '0, '0, '1, '0);
		send_request(CMD_RECORD, 16'h8000, '0, '1, '0);
		send_request(CMD_RECORD, '0, 16'h7FFF, '1, '0);
		send_request(CMD_RECORD, '0, '0, '0, '1);
		send_request(CMD_UNUSED, TURN_W'($urandom), TURN_W'($urandom), random_mask(),
			$urandom);
		send_request(CMD_PLAY, '0, '0, '0, 32'd0);
		send_request(CMD_PLAY, '0, '0, '0, 32'd1);
		send_request(CMD_PLAY, '0, '0, '0, 32'd2);
		send_request(CMD_PLAY, '0, '0, '0, 32'd5);
		send_request(CMD_PLAY, '0, '0, '0, 32'd4);
		send_request(CMD_PLAY, '0, '0, '0, 32'hFFFF_FFFF);
		send_request(CMD_CLEAR, '1, '1, '1, '1);
		send_request(CMD_PLAY, '0, '0, '0, 32'd0);
		send_request(CMD_RECORD, 16'hFFFF, 16'hFFFF, {16{4'h5}}, '0);
		send_request(CMD_PLAY, '0, '0, '0, 32'd0);
		send_request(CMD_RECORD, 16'h7FFF, 16'h8000, {16{4'hA}}, '0);
		send_request(CMD_PLAY, '0, '0, '0, 32'd1);

		// Fill the store and try to add past its limit, then record unchanged frames and search it.
		send_request(CMD_CLEAR, '0, '0, '0, '0);
		last_btn = random_mask();
		keys_added = 0;
		while (keys_added < MAX_KEYS + 6) begin
			if (keys_added > 0 && $urandom_range(0, 99) < 15) begin
				record_frame(REC_SAME);
			end else begin
				record_frame(REC_FLIP);
				keys_added++;
			end
		end
		repeat (3) record_frame(REC_SAME);
		repeat (40) play_frame();
		send_request(CMD_CLEAR, '0, '0, '0, '0);
		last_btn = '0;

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i % 200 == 0) begin
				no_gaps = ($urandom_range(0, 2) == 0);
			end
			r = $urandom_range(0, 99);
			if (r < 2) begin
				send_request(CMD_CLEAR, TURN_W'($urandom), TURN_W'($urandom),
					random_mask(), $urandom);
				last_btn = '0;
			end else if (r < 3) begin
				send_request(CMD_UNUSED, TURN_W'($urandom), TURN_W'($urandom),
					random_mask(), $urandom);
			end else if (r < 50) begin
				record_frame(REC_MIX);
			end else begin
				play_frame();
			end
		end
		in_valid <= 1'b0;

		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("input_change_recorder_player_top_tb: PASS");
		end else begin
			$display("input_change_recorder_player_top_tb: FAIL");
		end
		$finish;
	end

endmodule
